>>> hw/rtl/lcuvh_pkg.sv
// Shared constants, codes and types of the luma-corrected UV histogram.
package lcuvh_pkg;

  localparam int BINS_PER_AXIS = 64;
  localparam int COUNT_W       = 32;
  localparam int BIN_W         = (BINS_PER_AXIS > 1) ? $clog2(BINS_PER_AXIS) : 1;
  localparam int DEPTH         = BINS_PER_AXIS * BINS_PER_AXIS;
  localparam int ADDR_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int CHROMA_W  = 8;
  localparam int LUMA_W    = 8;
  // |c - 128| * 64 reaches 8192
  localparam int MAG_W     = 14;
  localparam int DIV_STEPS = MAG_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BIN_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LUMA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LUMA = 2'd2;

  typedef struct packed {
    logic              start;
    logic [LUMA_W-1:0] divisor;
    logic [MAG_W-1:0]  dividend_u;
    logic [MAG_W-1:0]  dividend_v;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quot_u;
    logic [MAG_W-1:0] quot_v;
  } div_rsp_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] data;
  } ram_wr_t;

endpackage

>>> hw/rtl/lcuvh_ram.sv
// Bin counter memory: one write port, one registered read port.
module lcuvh_ram (
  input  logic                        clk,
  input  lcuvh_pkg::ram_wr_t          wr,
  input  logic [lcuvh_pkg::ADDR_W-1:0] rd_addr,
  output logic [lcuvh_pkg::COUNT_W-1:0] rd_data
);
  import lcuvh_pkg::*;

  logic [COUNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/lcuvh_div.sv
// Two-lane restoring divider: chroma magnitudes by luma, one quotient bit a cycle.
module lcuvh_div (
  input  logic                clk,
  input  logic                rst,
  input  lcuvh_pkg::div_req_t req,
  output lcuvh_pkg::div_rsp_t rsp
);
  import lcuvh_pkg::*;

  logic                busy;
  logic                done;
  logic [STEP_W-1:0]   step;
  logic [LUMA_W-1:0]   divisor;
  logic [LUMA_W-1:0]   rem_u, rem_v;
  logic [MAG_W-1:0]    quo_u, quo_v;
  logic [LUMA_W+MAG_W-1:0] nxt_u, nxt_v;

  // shift in one dividend bit, subtract when it fits
  function automatic logic [LUMA_W+MAG_W-1:0] div_step(
    input logic [LUMA_W-1:0] rem,
    input logic [MAG_W-1:0]  quo,
    input logic [LUMA_W-1:0] den
  );
    logic [LUMA_W:0]   trial;
    logic [LUMA_W-1:0] rem_n;
    logic              bit_n;
    trial = {rem, quo[MAG_W-1]};
    if (trial >= {1'b0, den}) begin
      rem_n = LUMA_W'(trial - {1'b0, den});
      bit_n = 1'b1;
    end else begin
      rem_n = trial[LUMA_W-1:0];
      bit_n = 1'b0;
    end
    return {rem_n, quo[MAG_W-2:0], bit_n};
  endfunction

  assign nxt_u = div_step(rem_u, quo_u, divisor);
  assign nxt_v = div_step(rem_v, quo_v, divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      rem_u   <= '0;
      rem_v   <= '0;
      quo_u   <= req.dividend_u;
      quo_v   <= req.dividend_v;
    end else if (busy) begin
      {rem_u, quo_u} <= nxt_u;
      {rem_v, quo_v} <= nxt_v;
    end
  end

  assign rsp.done   = done;
  assign rsp.quot_u = quo_u;
  assign rsp.quot_v = quo_v;

endmodule

>>> hw/rtl/luma_corrected_uv_histogram_top.sv
// Top level of the luma-corrected UV histogram with back-projection.
//
// Input channel (in_valid/in_ready) takes one pixel word: opcode, U, V, Y.
// Opcode accumulate adds the pixel to its 2-D chroma bin; opcode query
// reports whether that bin is populated. Output channel (out_valid/out_ready)
// gives one result word per pixel: hit, counted, bin indices and bin count.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes bin_size,
// min_luma and max_luma; it is always ready.
//
// From one accept to the next, each pixel passes the two-lane bit-serial
// divider (Y into the luma-scaled chroma offset), a hand-over, the bit-serial
// bin-size divider, a read of the bin counter from memory, its write-back and
// a return to idle.
// One pixel is in flight at a time, so no read-after-write hazard exists.
//
// After reset the block sweeps the 4096-entry counter memory to zero, one
// entry a cycle, with in_ready low; config writes still land.
// A waiting result sits in the output register while the next pixel is
// taken and processed; that pixel then holds in its last step until the
// receiver takes the earlier word.
module luma_corrected_uv_histogram_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            opcode,
  input  logic [7:0]                      u_chroma,
  input  logic [7:0]                      v_chroma,
  input  logic [7:0]                      luma,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            hit,
  output logic                            counted,
  output logic [5:0]                      u_bin,
  output logic [5:0]                      v_bin,
  output logic [31:0]                     bin_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lcuvh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcuvh_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lcuvh_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_BDIV,
    ST_BIN,
    ST_UPD,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic         hit;
    logic         counted;
    logic [5:0]   ub;
    logic [5:0]   vb;
    logic [31:0]  cnt;
  } res_t;

  state_t              state;
  logic [ADDR_W-1:0]   clr_addr;

  logic [8:0]          bin_size;
  logic [7:0]          min_luma;
  logic [7:0]          max_luma;

  logic                opc;
  logic                neg_u, neg_v;
  logic                y_zero;
  logic                win;
  logic                strict;
  logic                u_ok;
  logic [BIN_W-1:0]    ub, vb;
  logic [ADDR_W-1:0]   addr;
  res_t                res;

  logic [2:0]          bstep;
  logic [8:0]          brem_u, brem_v;
  logic [7:0]          bquo_u, bquo_v;
  logic [16:0]         bnxt_u, bnxt_v;

  logic                in_accept;
  logic                out_free;
  logic                out_load;
  logic [7:0]          lo, hi;
  logic [8:0]          bs_eff;
  logic [BIN_W-1:0]    ub_c, vb_c;
  logic [ADDR_W-1:0]   addr_c;
  logic [COUNT_W-1:0]  old_cnt;
  logic [COUNT_W-1:0]  new_cnt;
  logic                do_inc;
  res_t                res_c;

  div_req_t            div_req;
  div_rsp_t            div_rsp;
  ram_wr_t             ram_wr;

  function automatic logic [MAG_W-1:0] chroma_mag(input logic [7:0] c);
    logic [7:0] diff;
    diff = (c < 8'd128) ? 8'(8'd128 - c) : 8'(c - 8'd128);
    return {diff, 6'b0};
  endfunction

  // offset back around 128, clamped to a byte
  function automatic logic [7:0] recenter(input logic [MAG_W-1:0] q, input logic neg);
    logic [7:0] r;
    if (neg) begin
      r = (q >= MAG_W'(128)) ? 8'd0 : 8'(MAG_W'(128) - q);
    end else begin
      r = (q >= MAG_W'(128)) ? 8'd255 : 8'(MAG_W'(128) + q);
    end
    return r;
  endfunction

  // shift in one numerator bit, subtract the bin size when it fits
  function automatic logic [16:0] bin_step(input logic [8:0] rem, input logic [7:0] q,
                                           input logic [8:0] den);
    logic [9:0] trial;
    logic [8:0] rem_n;
    logic       bit_n;
    trial = {rem, q[7]};
    if (trial >= {1'b0, den}) begin
      rem_n = 9'(trial - {1'b0, den});
      bit_n = 1'b1;
    end else begin
      rem_n = trial[8:0];
      bit_n = 1'b0;
    end
    return {rem_n, q[6:0], bit_n};
  endfunction

  function automatic logic [BIN_W-1:0] bin_clamp(input logic [7:0] q);
    if (int'(q) >= BINS_PER_AXIS) begin
      return BIN_W'(BINS_PER_AXIS - 1);
    end
    return BIN_W'(q);
  endfunction

  function automatic logic [31:0] sat_out(input logic [COUNT_W-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign out_load  = ((state == ST_UPD) || (state == ST_WAIT)) && out_free;

  assign lo     = (min_luma < 8'd1)   ? 8'd1   : min_luma;
  assign hi     = (max_luma > 8'd254) ? 8'd254 : max_luma;
  assign bs_eff = (bin_size < 9'd4) ? 9'd4 : ((bin_size > 9'd256) ? 9'd256 : bin_size);

  assign div_req.start      = in_accept;
  assign div_req.divisor    = luma;
  assign div_req.dividend_u = chroma_mag(u_chroma);
  assign div_req.dividend_v = chroma_mag(v_chroma);

  lcuvh_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign bnxt_u = bin_step(brem_u, bquo_u, bs_eff);
  assign bnxt_v = bin_step(brem_v, bquo_v, bs_eff);

  assign ub_c   = bin_clamp(bquo_u);
  assign vb_c   = bin_clamp(bquo_v);
  assign addr_c = ADDR_W'(int'(ub_c) * BINS_PER_AXIS + int'(vb_c));

  lcuvh_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (addr_c),
    .rd_data (old_cnt)
  );

  // read-modify-write of the bin, counter saturates
  always_comb begin
    do_inc  = (opc == OP_ACCUM) && u_ok && win && !y_zero;
    new_cnt = (do_inc && (old_cnt != '1)) ? old_cnt + 1'b1 : old_cnt;
    if (y_zero) begin
      res_c = '0;
    end else begin
      res_c.hit     = (opc == OP_QUERY) && strict && (old_cnt != '0);
      res_c.counted = do_inc;
      res_c.ub      = 6'(ub);
      res_c.vb      = 6'(vb);
      res_c.cnt     = sat_out(new_cnt);
    end
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      ram_wr.en   = 1'b1;
      ram_wr.addr = clr_addr;
      ram_wr.data = '0;
    end else begin
      ram_wr.en   = (state == ST_UPD) && do_inc;
      ram_wr.addr = addr;
      ram_wr.data = new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_size <= 9'd8;
      min_luma <= 8'd1;
      max_luma <= 8'd254;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BIN_SIZE: bin_size <= cfg_data;
        CFG_MIN_LUMA: min_luma <= cfg_data[7:0];
        CFG_MAX_LUMA: max_luma <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // pixel attributes captured at accept, so later luma-limit writes cannot bite; the bin size is read live
  always_ff @(posedge clk) begin
    if (in_accept) begin
      opc    <= opcode;
      neg_u  <= (u_chroma < 8'd128);
      neg_v  <= (v_chroma < 8'd128);
      y_zero <= (luma == 8'd0);
      win    <= (luma >= lo) && (luma <= hi);
      strict <= (luma > lo) && (luma < hi);
      u_ok   <= (u_chroma != 8'd255);
    end
    // load the recentered chroma, then divide it by the bin size
    if ((state == ST_DIV) && div_rsp.done) begin
      brem_u <= '0;
      brem_v <= '0;
      bquo_u <= recenter(div_rsp.quot_u, neg_u);
      bquo_v <= recenter(div_rsp.quot_v, neg_v);
    end else if (state == ST_BDIV) begin
      {brem_u, bquo_u} <= bnxt_u;
      {brem_v, bquo_v} <= bnxt_v;
    end
    if (state == ST_BIN) begin
      ub   <= ub_c;
      vb   <= vb_c;
      addr <= addr_c;
    end
    if (state == ST_UPD) begin
      res <= res_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      bstep     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            bstep <= '0;
            state <= ST_BDIV;
          end
        end
        ST_BDIV: begin
          bstep <= bstep + 1'b1;
          if (bstep == 3'(CHROMA_W - 1)) begin
            state <= ST_BIN;
          end
        end
        ST_BIN: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (out_free) begin
            hit       <= res_c.hit;
            counted   <= res_c.counted;
            u_bin     <= res_c.ub;
            v_bin     <= res_c.vb;
            bin_count <= res_c.cnt;
            state     <= ST_IDLE;
          end else begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          // hold until the earlier word leaves
          if (out_free) begin
            hit       <= res.hit;
            counted   <= res.counted;
            u_bin     <= res.ub;
            v_bin     <= res.vb;
            bin_count <= res.cnt;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_DIV))
    else $error("accepted pixel did not enter the divider");

  a_write_only_accum: assert property (@(posedge clk) disable iff (rst)
    (ram_wr.en && (state != ST_CLEAR)) |-> ((state == ST_UPD) && (opc == OP_ACCUM)))
    else $error("counter written outside an accumulate update");

  a_hit_xor_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && counted))
    else $error("result word flags both hit and counted");

  a_flag_needs_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (hit || counted)) |-> (bin_count != 32'd0))
    else $error("flagged result word reports an empty bin");

endmodule

>>> bench/luma_corrected_uv_histogram_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the luma-corrected UV histogram: predicts every result word.
module luma_corrected_uv_histogram_top_tb;
  import lcuvh_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic               hit;
    logic               counted;
    logic [BIN_W-1:0]   u_bin;
    logic [BIN_W-1:0]   v_bin;
    logic [COUNT_W-1:0] bin_count;
  } bin_report_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  opcode;
  logic [7:0]            u_chroma;
  logic [7:0]            v_chroma;
  logic [7:0]            luma;
  logic                  out_valid;
  logic                  out_ready;
  logic                  hit;
  logic                  counted;
  logic [5:0]            u_bin;
  logic [5:0]            v_bin;
  logic [31:0]           bin_count;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state: counters and register copies
  logic [COUNT_W-1:0] bin_tally [DEPTH];
  logic [8:0]         bin_size_q = 9'd8;
  logic [7:0]         min_luma_q = 8'd1;
  logic [7:0]         max_luma_q = 8'd254;

  bin_report_t pending_reports[$];
  int          errors = 0;
  bit          src_gaps = 1'b1;
  bit          sink_stalls = 1'b1;
  int          sink_hold = 0;

  luma_corrected_uv_histogram_top dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int usable_bin_size();
    if (bin_size_q < 9'd4) return 4;
    if (bin_size_q > 9'd256) return 256;
    return int'(bin_size_q);
  endfunction

  // y must be nonzero
  function automatic logic [BIN_W-1:0] corrected_index(input logic [7:0] c,
                                                       input logic [7:0] y);
    int mag;
    int r;
    int idx;
    if (c < 8'd128) begin
      mag = (128 - int'(c)) * 64;
      r = 128 - mag / int'(y);
    end else begin
      mag = (int'(c) - 128) * 64;
      r = 128 + mag / int'(y);
    end
    if (r < 0) r = 0;
    if (r > 255) r = 255;
    idx = r / usable_bin_size();
    if (idx >= BINS_PER_AXIS) idx = BINS_PER_AXIS - 1;
    return idx[BIN_W-1:0];
  endfunction

  function automatic bin_report_t account_pixel(input logic op, input logic [7:0] u,
                                                input logic [7:0] v, input logic [7:0] y);
    bin_report_t       rep;
    logic [7:0]        lo;
    logic [7:0]        hi;
    logic [ADDR_W-1:0] addr;
    rep = '0;
    lo = (min_luma_q < 8'd1) ? 8'd1 : min_luma_q;
    hi = (max_luma_q > 8'd254) ? 8'd254 : max_luma_q;
    if (y != 8'd0) begin
      rep.u_bin = corrected_index(u, y);
      rep.v_bin = corrected_index(v, y);
      addr = ADDR_W'(rep.u_bin * BINS_PER_AXIS + rep.v_bin);
      if (op == OP_ACCUM) begin
        if (u != 8'hFF && y >= lo && y <= hi) begin
          rep.counted = 1'b1;
          // saturate at full scale
          if (bin_tally[addr] != '1) bin_tally[addr] = bin_tally[addr] + 1'b1;
        end
      end else if (y > lo && y < hi && bin_tally[addr] != '0) begin
        rep.hit = 1'b1;
      end
      rep.bin_count = bin_tally[addr];
    end
    return rep;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  task automatic check_report();
    bin_report_t want;
    if (pending_reports.size() == 0) begin
      errors++;
      $display("%0t: result word with none pending: expected none, got bin (%0d,%0d) count %0d",
               $time, u_bin, v_bin, bin_count);
    end else begin
      want = pending_reports.pop_front();
      compare_field("hit", 32'(want.hit), 32'(hit));
      compare_field("counted", 32'(want.counted), 32'(counted));
      compare_field("u_bin", 32'(want.u_bin), 32'(u_bin));
      compare_field("v_bin", 32'(want.v_bin), 32'(v_bin));
      compare_field("bin_count", 32'(want.bin_count), bin_count);
    end
  endtask

  task automatic send_pixel(input logic op, input logic [7:0] u, input logic [7:0] v,
                            input logic [7:0] y);
    int gap;
    gap = src_gaps ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    u_chroma <= u;
    v_chroma <= v;
    luma     <= y;
    do @(posedge clk); while ((in_valid && in_ready) !== 1'b1);
    pending_reports.push_back(account_pixel(op, u, v, y));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while ((cfg_valid && cfg_ready) !== 1'b1);
    case (idx)
      CFG_BIN_SIZE: bin_size_q = data;
      CFG_MIN_LUMA: min_luma_q = data[7:0];
      CFG_MAX_LUMA: max_luma_q = data[7:0];
      default: ;
    endcase
  endtask

  // upper data bit is don't-care for the luma limits; toggle it anyway
  task automatic program_registers(input logic [8:0] bsz, input logic [7:0] lo,
                                   input logic [7:0] hi);
    wait_idle();
    write_register(CFG_BIN_SIZE, bsz);
    write_register(CFG_MIN_LUMA, {1'($urandom_range(0, 1)), lo});
    write_register(CFG_MAX_LUMA, {1'($urandom_range(0, 1)), hi});
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_pixel(OP_QUERY, 8'd128, 8'd128, 8'd128);
    send_pixel(OP_ACCUM, 8'd0, 8'd0, 8'd1);
    send_pixel(OP_ACCUM, 8'd255, 8'd255, 8'd1);
    send_pixel(OP_ACCUM, 8'd254, 8'd1, 8'd1);
    send_pixel(OP_ACCUM, 8'd128, 8'd128, 8'd254);
    send_pixel(OP_ACCUM, 8'd128, 8'd128, 8'd255);
    send_pixel(OP_ACCUM, 8'd40, 8'd200, 8'd0);
    send_pixel(OP_QUERY, 8'd40, 8'd200, 8'd0);
    send_pixel(OP_QUERY, 8'd128, 8'd128, 8'd254);
    send_pixel(OP_QUERY, 8'd128, 8'd128, 8'd2);
    send_pixel(OP_QUERY, 8'd254, 8'd1, 8'd1);
  endtask

  task automatic test_bin_sizes();
    logic [8:0] sizes [5];
    sizes = '{9'd0, 9'd3, 9'd4, 9'd256, 9'd511};
    foreach (sizes[i]) begin
      program_registers(sizes[i], 8'd0, 8'd255);
      send_pixel((i % 2 == 0) ? OP_ACCUM : OP_QUERY, 8'd250, 8'd5, 8'd3);
    end
  endtask

  task automatic test_luma_window();
    wait_idle();
    write_register(CFG_SPARE, 9'h1FF);
    // single-value window: counts, never hits
    program_registers(9'd8, 8'd100, 8'd100);
    send_pixel(OP_ACCUM, 8'd130, 8'd126, 8'd100);
    send_pixel(OP_QUERY, 8'd130, 8'd126, 8'd100);
    // inverted window
    program_registers(9'd8, 8'd200, 8'd50);
    send_pixel(OP_ACCUM, 8'd128, 8'd128, 8'd120);
    send_pixel(OP_QUERY, 8'd128, 8'd128, 8'd120);
    program_registers(9'd8, 8'd255, 8'd0);
    send_pixel(OP_ACCUM, 8'd128, 8'd128, 8'd1);
    program_registers(9'd8, 8'd0, 8'd255);
    send_pixel(OP_QUERY, 8'd130, 8'd126, 8'd100);
    send_pixel(OP_ACCUM, 8'd128, 8'd128, 8'd255);
  endtask

  task automatic test_backpressure();
    wait_idle();
    src_gaps = 1'b0;
    sink_hold = HOLD_CYCLES;
    repeat (12) begin
      send_pixel(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)));
    end
    src_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [7:0] cu [4];
    logic [7:0] cv [4];
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] ylo;
    logic [7:0] yhi;
    logic [7:0] u;
    logic [7:0] v;
    logic [7:0] y;
    logic [8:0] bsz;
    int         phase;
    int         n;
    int         pick;
    int         k;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: bsz = 9'd4;
        1: bsz = 9'd256;
        2: bsz = 9'd511;
        3: bsz = 9'd8;
        default: bsz = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                                   : 9'($urandom_range(4, 32));
      endcase
      if (phase == 2) begin
        lo = 8'd255;
        hi = 8'd0;
      end else if (phase == 5) begin
        lo = 8'd0;
        hi = 8'd255;
      end else begin
        lo = 8'($urandom_range(0, 60));
        hi = 8'($urandom_range(180, 255));
      end
      program_registers(bsz, lo, hi);
      src_gaps = (phase != 3);
      sink_stalls = (phase != 4);
      ylo = (lo < 8'd1) ? 8'd1 : lo;
      yhi = (hi > 8'd254) ? 8'd254 : hi;
      for (k = 0; k < 4; k++) begin
        cu[k] = 8'($urandom_range(96, 160));
        cv[k] = 8'($urandom_range(96, 160));
      end
      for (n = 0; n < 100; n++) begin
        pick = $urandom_range(0, 9);
        k = $urandom_range(0, 3);
        // cluster pixels land in populated bins so queries can hit
        u = 8'(int'(cu[k]) + $urandom_range(0, 8) - 4);
        v = 8'(int'(cv[k]) + $urandom_range(0, 8) - 4);
        y = (ylo <= yhi) ? 8'($urandom_range(ylo, yhi)) : 8'($urandom_range(1, 255));
        if (pick < 4) begin
          send_pixel(OP_ACCUM, u, v, y);
        end else if (pick < 7) begin
          send_pixel(OP_QUERY, u, v, y);
        end else if (pick < 9) begin
          send_pixel(OP_QUERY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(1, 255)));
        end else begin
          send_pixel(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
      end
    end
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (sink_hold > 0) begin
        out_ready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end
      stall = sink_stalls ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while ((out_valid && out_ready) !== 1'b1);
      check_report();
    end
  end

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    opcode    <= OP_ACCUM;
    u_chroma  <= 8'd0;
    v_chroma  <= 8'd0;
    luma      <= 8'd0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_BIN_SIZE;
    cfg_data  <= '0;
    foreach (bin_tally[i]) bin_tally[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_bin_sizes();
    test_luma_window();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    // let any stray word show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
